// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define SCA_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked assertion without a disable condition
`define SCA_ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ----- src/sca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sca_pkg
// shared types, codes and size-class helpers of the block allocator
// ----------------------------------------------------------------------------
package sca_pkg;

   localparam int CLASSES = 5;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic CSR_TOTAL = 1'b0;
   localparam logic CSR_ALIGN = 1'b1;

   localparam logic [40:0] TOTAL_RESET   = 41'd1073741824;
   localparam logic [16:0] ALIGN_RESET   = 17'd4096;
   localparam logic [16:0] ALIGN_DEFAULT = 17'd4096;
   localparam logic [17:0] CHUNK_BYTES   = 18'd131072;

   typedef struct packed {
      logic [17:0] bytes;
      logic [39:0] offset;
   } entry_type;

   typedef struct packed {
      logic [2:0] cls;
      entry_type  ent;
   } chunk_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHUNK,
      ST_POP_CHK,
      ST_POP_DATA,
      ST_HEAP_WAIT,
      ST_RB_BUF,
      ST_RB_META,
      ST_PUSH,
      ST_EM_RD,
      ST_EM_LOAD,
      ST_RESP
   } state_type;

   function automatic logic [17:0] cls_size(input logic [2:0] c);
      logic [17:0] s;
      unique case (c)
         3'd0:    s = 18'd4096;
         3'd1:    s = 18'd16384;
         3'd2:    s = 18'd32768;
         3'd3:    s = 18'd65536;
         default: s = 18'd131072;
      endcase
      return s;
   endfunction

   function automatic logic [2:0] cls_of(input logic [17:0] sz);
      logic [2:0] c;
      priority if (sz <= 18'd4096)  c = 3'd0;
      else if (sz <= 18'd16384)     c = 3'd1;
      else if (sz <= 18'd32768)     c = 3'd2;
      else if (sz <= 18'd65536)     c = 3'd3;
      else                          c = 3'd4;
      return c;
   endfunction

endpackage

// ----- src/sca_list_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sca_list_store
// free-list entry memory and per-list head/count memory, registered reads
// ----------------------------------------------------------------------------
module sca_list_store import sca_pkg::*; #(
   parameter int NLISTS     = 40,
   parameter int LIST_DEPTH = 64,
   parameter int LW         = 6,
   parameter int HW         = 6,
   parameter int CNW        = 7,
   parameter int AW         = 12
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            meta_rd_en,
   input  logic [LW-1:0]   meta_raddr,
   output logic [HW-1:0]   meta_rd_head,
   output logic [CNW-1:0]  meta_rd_count,
   input  logic            meta_we,
   input  logic [LW-1:0]   meta_waddr,
   input  logic [HW-1:0]   meta_wr_head,
   input  logic [CNW-1:0]  meta_wr_count,
   input  logic            ent_rd_en,
   input  logic [AW-1:0]   ent_raddr,
   output entry_type       ent_rd,
   input  logic            ent_we,
   input  logic [AW-1:0]   ent_waddr,
   input  entry_type       ent_wr
);

   entry_type        ent_mem [NLISTS*LIST_DEPTH];
   logic [HW-1:0]    head_mem [NLISTS];
   logic [CNW-1:0]   count_mem [NLISTS];
   logic [NLISTS-1:0] meta_valid_ff;
   logic             rd_valid_ff;
   logic [HW-1:0]    rd_head_ff;
   logic [CNW-1:0]   rd_count_ff;
   entry_type        ent_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         if (meta_we) meta_valid_ff[meta_waddr] <= 1'b1;
         if (meta_rd_en) rd_valid_ff <= meta_valid_ff[meta_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         head_mem[meta_waddr]  <= meta_wr_head;
         count_mem[meta_waddr] <= meta_wr_count;
      end
      if (meta_rd_en) begin
         rd_head_ff  <= head_mem[meta_raddr];
         rd_count_ff <= count_mem[meta_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_waddr] <= ent_wr;
      if (ent_rd_en) ent_rd_ff <= ent_mem[ent_raddr];
   end

   // lists never written read as empty
   assign meta_rd_head  = rd_valid_ff ? rd_head_ff : '0;
   assign meta_rd_count = rd_valid_ff ? rd_count_ff : '0;
   assign ent_rd        = ent_rd_ff;

endmodule

// ----- src/sca_align_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sca_align_div
// aligned block size: ceil(size / align) * align when fed size + align - 1, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sca_align_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [17:0] dividend,
   input  logic [16:0] divisor,
   output logic        done,
   output logic [17:0] size
);

   localparam logic [4:0] LAST_STEP = 5'd17;

   logic        busy_ff, mul_ff, done_ff;
   logic [4:0]  cnt_ff;
   logic [17:0] num_ff, quo_ff, rem_ff, size_ff;
   logic [16:0] den_ff;
   logic [17:0] trial;
   logic        fits;

   assign trial = {rem_ff[16:0], num_ff[17]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= mul_ff;
         mul_ff  <= busy_ff && (cnt_ff == LAST_STEP);
         if (start) busy_ff <= 1'b1;
         else if (busy_ff && (cnt_ff == LAST_STEP)) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         den_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? (trial - {1'b0, den_ff}) : trial;
         quo_ff <= {quo_ff[16:0], fits};
         num_ff <= {num_ff[16:0], 1'b0};
         cnt_ff <= cnt_ff + 5'd1;
      end
      // result always fits 18 bits for power-of-two sizes
      if (mul_ff) size_ff <= 18'(quo_ff * den_ff);
   end

   assign done = done_ff;
   assign size = size_ff;

endmodule

// ----- src/size_class_block_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_block_allocator_unit
// per-worker size-class free lists in front of a bump heap
// ----------------------------------------------------------------------------
// One item is handled at a time. A free item reads its list's head and count,
// then pushes the block, then waits for the result handshake. An allocate item
// is cut into 128K chunks and a remainder; each chunk first tries its own list,
// then probes neighbor lists, and is carved from the heap last, once the serial
// aligned-size divider has finished. Results of a successful allocate then go
// out one at a time through the chunk buffer read and the output register. A
// failed allocate gives blocks back one at a time (buffer read, list head/count
// read, write). The free-list memory is undefined until written; list heads and
// counts reset at once through valid bits, so no clearing pass runs after reset.
// ----------------------------------------------------------------------------
module size_class_block_allocator_unit import sca_pkg::*; #(
   parameter int WORKERS     = 8,
   parameter int LIST_DEPTH  = 64,
   parameter int MAX_CHUNKS  = 64,
   parameter int STEAL_TRIES = 4
) (
   input  logic         clock,
   input  logic         reset,
   // request items
   input  logic         req_tvalid,
   output logic         req_tready,
   // worker[2:0], request_bytes[26:3], block_offset[66:27],
   // block_bytes[84:67], block_class[87:85]
   input  logic [87:0]  req_tdata,
   // func[0]
   input  logic         req_tuser,
   // result items
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_offset[39:0], out_bytes[57:40], out_class[60:58],
   // remaining_bytes[101:61], zero fill[103:102]
   output logic [103:0] rsp_tdata,
   // status[1:0], block_valid[2]
   output logic [2:0]   rsp_tuser,
   output logic         rsp_tlast,
   // register writes
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [40:0]  csr_data
);

   localparam int NLISTS = WORKERS * CLASSES;
   localparam int LW     = $clog2(NLISTS);
   localparam int HW     = $clog2(LIST_DEPTH);
   localparam int CNW    = $clog2(LIST_DEPTH + 1);
   localparam int AW     = $clog2(NLISTS * LIST_DEPTH);
   localparam int WW     = (WORKERS > 1) ? $clog2(WORKERS) : 1;
   localparam int NSTEAL = (STEAL_TRIES < WORKERS - 1) ? STEAL_TRIES : WORKERS - 1;
   localparam int TW     = (NSTEAL > 0) ? $clog2(NSTEAL + 1) : 1;
   localparam int KW     = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int CW     = $clog2(MAX_CHUNKS + 1);

   // 3-bit worker index modulo WORKERS by repeated subtraction
   function automatic logic [WW-1:0] wrap_worker(input logic [2:0] v);
      logic [7:0] t;
      t = {5'd0, v};
      for (int i = 0; i < 8; i++)
         if (t >= 8'(WORKERS)) t = t - 8'(WORKERS);
      return WW'(t);
   endfunction

   function automatic logic [LW-1:0] list_of(input logic [WW-1:0] w, input logic [2:0] c);
      return LW'(int'(w) * CLASSES + int'(c));
   endfunction

   function automatic logic [AW-1:0] ent_addr(input logic [LW-1:0] l,
                                               input logic [HW-1:0] pos);
      return AW'(int'(l) * LIST_DEPTH + int'(pos));
   endfunction

   // request fields
   logic [2:0]  f_worker;
   logic [23:0] f_req;
   logic [39:0] f_off;
   logic [17:0] f_bytes;
   logic [2:0]  f_cls;
   assign f_worker = req_tdata[2:0];
   assign f_req    = req_tdata[26:3];
   assign f_off    = req_tdata[66:27];
   assign f_bytes  = req_tdata[84:67];
   assign f_cls    = req_tdata[87:85];

   state_type   state_ff, state_in;
   logic        is_free_ff, is_free_in;
   logic [WW-1:0] worker_ff, worker_in, victim_ff, victim_in;
   logic [TW-1:0] tries_ff, tries_in;
   logic [2:0]  cls_ff, cls_in;
   logic [LW-1:0] list_ff, list_in;
   logic [CW-1:0] k_ff, k_in, j_ff, j_in, chunks_ff, chunks_in;
   logic [6:0]  full_ff, full_in;
   logic [16:0] rem_ff, rem_in;
   entry_type   push_ent_ff, push_ent_in;
   logic [40:0] heap_top_ff, heap_top_in;
   logic [40:0] total_ff;
   logic [16:0] align_ff;

   // output register
   logic        rsp_valid_ff, rsp_last_ff, rsp_bvalid_ff;
   logic [1:0]  rsp_status_ff;
   entry_type   rsp_ent_ff;
   logic [2:0]  rsp_cls_ff;
   logic [40:0] rsp_remain_ff;
   logic        ld, ld_bvalid, ld_last;
   logic [1:0]  ld_status;
   entry_type   ld_ent;
   logic [2:0]  ld_cls;

   // list store control
   logic          meta_rd_en, meta_we, ent_rd_en, ent_we;
   logic [LW-1:0] meta_raddr, meta_waddr;
   logic [HW-1:0] meta_rd_head, meta_wr_head;
   logic [CNW-1:0] meta_rd_count, meta_wr_count;
   logic [AW-1:0] ent_raddr, ent_waddr;
   entry_type     ent_rd, ent_wr;

   // chunk buffer: blocks taken by the current allocate
   chunk_type     buf_mem [MAX_CHUNKS];
   chunk_type     buf_q_ff;
   logic          buf_we, buf_rd_en;
   logic [KW-1:0] buf_waddr, buf_raddr;
   chunk_type     buf_wr;

   // heap size unit
   logic        div_start, div_done;
   logic [17:0] div_size;
   logic [16:0] align_eff;

   logic [41:0] heap_sum;
   logic [7:0]  nchunks;
   logic [17:0] chunk_sz;
   logic [2:0]  chunk_cls;
   logic [WW:0] victim_inc;
   logic [WW-1:0] victim_next;
   int          tail_sum;
   logic [HW-1:0] tail_pos, head_next;
   logic [CW-1:0] k_inc, j_inc;

   assign align_eff  = (align_ff == '0) ? ALIGN_DEFAULT : align_ff;
   assign heap_sum   = {1'b0, heap_top_ff} + {24'd0, div_size};
   assign nchunks    = {1'b0, f_req[23:17]} + {7'd0, (f_req[16:0] != '0)};
   assign chunk_sz   = (8'(k_ff) < {1'b0, full_ff}) ? CHUNK_BYTES : {1'b0, rem_ff};
   assign chunk_cls  = cls_of(chunk_sz);
   assign victim_inc = {1'b0, victim_ff} + 1'b1;
   assign victim_next = (victim_inc == (WW+1)'(WORKERS)) ? '0 : victim_inc[WW-1:0];
   assign tail_sum   = int'(meta_rd_head) + int'(meta_rd_count);
   assign tail_pos   = HW'((tail_sum >= LIST_DEPTH) ? tail_sum - LIST_DEPTH : tail_sum);
   assign head_next  = (int'(meta_rd_head) + 1 == LIST_DEPTH) ? '0 : meta_rd_head + 1'b1;
   assign k_inc      = k_ff + 1'b1;
   assign j_inc      = j_ff + 1'b1;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in      = state_ff;
      is_free_in    = is_free_ff;
      worker_in     = worker_ff;
      victim_in     = victim_ff;
      tries_in      = tries_ff;
      cls_in        = cls_ff;
      list_in       = list_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      chunks_in     = chunks_ff;
      full_in       = full_ff;
      rem_in        = rem_ff;
      push_ent_in   = push_ent_ff;
      heap_top_in   = heap_top_ff;
      ld            = 1'b0;
      ld_status     = STATUS_OK;
      ld_bvalid     = 1'b0;
      ld_ent        = '0;
      ld_cls        = '0;
      ld_last       = 1'b1;
      meta_rd_en    = 1'b0;
      meta_raddr    = list_ff;
      meta_we       = 1'b0;
      meta_waddr    = list_ff;
      meta_wr_head  = meta_rd_head;
      meta_wr_count = meta_rd_count;
      ent_rd_en     = 1'b0;
      ent_raddr     = ent_addr(list_ff, meta_rd_head);
      ent_we        = 1'b0;
      ent_waddr     = ent_addr(list_ff, tail_pos);
      ent_wr        = push_ent_ff;
      buf_we        = 1'b0;
      buf_waddr     = k_ff[KW-1:0];
      buf_wr        = '0;
      buf_rd_en     = 1'b0;
      buf_raddr     = j_ff[KW-1:0];
      div_start     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               worker_in = wrap_worker(f_worker);
               if (req_tuser == FUNC_FREE) begin
                  if (f_cls < 3'(CLASSES)) begin
                     list_in     = list_of(wrap_worker(f_worker), f_cls);
                     meta_rd_en  = 1'b1;
                     meta_raddr  = list_of(wrap_worker(f_worker), f_cls);
                     push_ent_in = '{bytes: f_bytes, offset: f_off};
                     is_free_in  = 1'b1;
                     state_in    = ST_PUSH;
                  end else begin
                     // class out of range: block ignored
                     ld       = 1'b1;
                     state_in = ST_RESP;
                  end
               end else if (f_req == '0) begin
                  ld       = 1'b1;
                  state_in = ST_RESP;
               end else if (nchunks > 8'(MAX_CHUNKS)) begin
                  ld        = 1'b1;
                  ld_status = STATUS_NOSPACE;
                  state_in  = ST_RESP;
               end else begin
                  is_free_in    = 1'b0;
                  k_in          = '0;
                  chunks_in     = CW'(nchunks);
                  full_in       = f_req[23:17];
                  rem_in        = f_req[16:0];
                  state_in      = ST_CHUNK;
               end
            end
         end
         ST_CHUNK: begin
            cls_in     = chunk_cls;
            list_in    = list_of(worker_ff, chunk_cls);
            meta_rd_en = 1'b1;
            meta_raddr = list_of(worker_ff, chunk_cls);
            victim_in  = worker_ff;
            tries_in   = '0;
            state_in   = ST_POP_CHK;
         end
         ST_POP_CHK: begin
            if (meta_rd_count != '0) begin
               ent_rd_en     = 1'b1;
               meta_we       = 1'b1;
               meta_wr_head  = head_next;
               meta_wr_count = meta_rd_count - 1'b1;
               state_in      = ST_POP_DATA;
            end else if (tries_ff < TW'(NSTEAL)) begin
               // probe the next neighbor's list
               victim_in  = victim_next;
               tries_in   = tries_ff + 1'b1;
               list_in    = list_of(victim_next, cls_ff);
               meta_rd_en = 1'b1;
               meta_raddr = list_of(victim_next, cls_ff);
            end else begin
               div_start = 1'b1;
               state_in  = ST_HEAP_WAIT;
            end
         end
         ST_POP_DATA: begin
            buf_we = 1'b1;
            buf_wr = '{cls: cls_ff, ent: ent_rd};
            k_in   = k_inc;
            if (k_inc == chunks_ff) begin
               j_in     = '0;
               state_in = ST_EM_RD;
            end else begin
               state_in = ST_CHUNK;
            end
         end
         ST_HEAP_WAIT: begin
            if (div_done) begin
               if (heap_sum <= {1'b0, total_ff}) begin
                  buf_we      = 1'b1;
                  buf_wr      = '{cls: cls_ff,
                                  ent: '{bytes: div_size, offset: heap_top_ff[39:0]}};
                  heap_top_in = heap_sum[40:0];
                  k_in        = k_inc;
                  if (k_inc == chunks_ff) begin
                     j_in     = '0;
                     state_in = ST_EM_RD;
                  end else begin
                     state_in = ST_CHUNK;
                  end
               end else begin
                  // out of space: heap pointer stays, give taken blocks back
                  j_in        = '0;
                  if (k_ff == '0) begin
                     ld        = 1'b1;
                     ld_status = STATUS_NOSPACE;
                     state_in  = ST_RESP;
                  end else begin
                     state_in = ST_RB_BUF;
                  end
               end
            end
         end
         ST_RB_BUF: begin
            buf_rd_en = 1'b1;
            state_in  = ST_RB_META;
         end
         ST_RB_META: begin
            list_in     = list_of(worker_ff, buf_q_ff.cls);
            push_ent_in = buf_q_ff.ent;
            meta_rd_en  = 1'b1;
            meta_raddr  = list_of(worker_ff, buf_q_ff.cls);
            state_in    = ST_PUSH;
         end
         ST_PUSH: begin
            if (int'(meta_rd_count) < LIST_DEPTH) begin
               ent_we        = 1'b1;
               meta_we       = 1'b1;
               meta_wr_count = meta_rd_count + 1'b1;
            end
            if (is_free_ff) begin
               ld        = 1'b1;
               ld_status = (int'(meta_rd_count) < LIST_DEPTH) ? STATUS_OK : STATUS_FULL;
               state_in  = ST_RESP;
            end else begin
               j_in = j_inc;
               if (j_inc == k_ff) begin
                  ld        = 1'b1;
                  ld_status = STATUS_NOSPACE;
                  state_in  = ST_RESP;
               end else begin
                  state_in = ST_RB_BUF;
               end
            end
         end
         ST_EM_RD: begin
            buf_rd_en = 1'b1;
            state_in  = ST_EM_LOAD;
         end
         ST_EM_LOAD: begin
            ld        = 1'b1;
            ld_bvalid = 1'b1;
            ld_ent    = buf_q_ff.ent;
            ld_cls    = buf_q_ff.cls;
            ld_last   = (j_inc == chunks_ff);
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) begin
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  j_in     = j_inc;
                  state_in = ST_EM_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         heap_top_ff  <= '0;
         total_ff     <= TOTAL_RESET;
         align_ff     <= ALIGN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         heap_top_ff <= heap_top_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_TOTAL: total_ff <= csr_data;
               CSR_ALIGN: align_ff <= csr_data[16:0];
               default:   total_ff <= total_ff;
            endcase
         end
         if (ld) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      is_free_ff    <= is_free_in;
      worker_ff     <= worker_in;
      victim_ff     <= victim_in;
      tries_ff      <= tries_in;
      cls_ff        <= cls_in;
      list_ff       <= list_in;
      k_ff          <= k_in;
      j_ff          <= j_in;
      chunks_ff     <= chunks_in;
      full_ff       <= full_in;
      rem_ff        <= rem_in;
      push_ent_ff   <= push_ent_in;
      if (ld) begin
         rsp_status_ff <= ld_status;
         rsp_bvalid_ff <= ld_bvalid;
         rsp_ent_ff    <= ld_ent;
         rsp_cls_ff    <= ld_cls;
         rsp_last_ff   <= ld_last;
         // heap state after this item
         rsp_remain_ff <= (heap_top_in >= total_ff) ? '0 : (total_ff - heap_top_in);
      end
   end

   // chunk buffer memory
   always_ff @(posedge clock) begin
      if (buf_we) buf_mem[buf_waddr] <= buf_wr;
      if (buf_rd_en) buf_q_ff <= buf_mem[buf_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_bvalid_ff, rsp_status_ff};
   assign rsp_tdata  = {2'b00, rsp_remain_ff, rsp_cls_ff, rsp_ent_ff.bytes,
                        rsp_ent_ff.offset};

   sca_list_store #(
      .NLISTS     (NLISTS),
      .LIST_DEPTH (LIST_DEPTH),
      .LW         (LW),
      .HW         (HW),
      .CNW        (CNW),
      .AW         (AW)
   ) u_lists (
      .clock         (clock),
      .reset         (reset),
      .meta_rd_en    (meta_rd_en),
      .meta_raddr    (meta_raddr),
      .meta_rd_head  (meta_rd_head),
      .meta_rd_count (meta_rd_count),
      .meta_we       (meta_we),
      .meta_waddr    (meta_waddr),
      .meta_wr_head  (meta_wr_head),
      .meta_wr_count (meta_wr_count),
      .ent_rd_en     (ent_rd_en),
      .ent_raddr     (ent_raddr),
      .ent_rd        (ent_rd),
      .ent_we        (ent_we),
      .ent_waddr     (ent_waddr),
      .ent_wr        (ent_wr)
   );

   sca_align_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cls_size(cls_ff) + {1'b0, align_eff} - 18'd1),
      .divisor  (align_eff),
      .done     (div_done),
      .size     (div_size)
   );

endmodule

// ----- src/sca_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sca_checker
// port-level checks of the block allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sca_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [87:0]  req_tdata,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata,
   input logic [2:0]   rsp_tuser,
   input logic         rsp_tlast,
   input logic         csr_valid,
   input logic         csr_ready,
   input logic         csr_index,
   input logic [40:0]  csr_data
);

   logic unused_ok;
   assign unused_ok = ^{req_tdata, req_tuser, csr_valid, csr_ready, csr_index, csr_data};

   // stalled result holds
   `SCA_ASSERT_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // one item at a time: busy right after an accept
   `SCA_ASSERT_RST(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready)
   // results without a block are single, final results
   `SCA_ASSERT_RST(a_single_last, clock, reset, rsp_tvalid && !rsp_tuser[2] |-> rsp_tlast)
   // nothing follows the final result until a new item arrives
   `SCA_ASSERT_RST(a_gap_after_last, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
   // a carried block always has ok status
   `SCA_ASSERT_CLK(a_block_ok, clock, !reset && rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1:0] == 2'd0 && unused_ok == unused_ok)

endmodule

bind size_class_block_allocator_unit sca_checker u_sca_checker (.*);
